[rtl/core/dit_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dit_pkg
// Shared types and sizes of the disjoint interval tracker.
// ---------------------------------------------------------------------------
package dit_pkg;

  localparam int unsigned MAX_INTERVALS = 16;
  localparam int unsigned VALUE_BITS    = 31;
  localparam int unsigned IDX_W         = $clog2(MAX_INTERVALS);
  localparam int unsigned CNT_W         = $clog2(MAX_INTERVALS + 1);

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_DUMP = 1'b1;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DUMP = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic                  result_kind;
    logic [VALUE_BITS-1:0] range_start;
    logic [VALUE_BITS-1:0] range_end;
    logic                  is_last;
    logic                  is_empty;
    logic                  status;
    logic [CNT_W-1:0]      interval_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic take;  // input transfer: capture value, run the parallel compare
    logic upd;   // apply the add and load the acknowledgement
    logic emit;  // load the next dump result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic dump_last;  // the dump result at hand is the final one
  } stat_t;

endpackage : dit_pkg
`default_nettype wire

[rtl/core/dit_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dit_ctrl
// Sequencer: accepts items, steps an add through its update state and a
// dump through one emit per reported interval, each while the output is free.
// ---------------------------------------------------------------------------
module dit_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_mode_i,
  output logic               in_ready_o,
  input  wire dit_pkg::stat_t stat_i,
  output dit_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DUMP
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.take = in_valid_i && ready_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.take) begin
          state_d = (in_mode_i == dit_pkg::MODE_DUMP) ? ST_DUMP : ST_UPD;
        end
      end
      ST_UPD: begin
        if (stat_i.out_free) begin
          cmd_o.upd = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule : dit_ctrl
`default_nettype wire

[rtl/core/dit_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dit_datapath
// Interval table, per-entry compare flags, shift-merge update, dump index
// and the output register.
// ---------------------------------------------------------------------------
module dit_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dit_pkg::in_t   in_data_i,
  input  wire dit_pkg::cmd_t  cmd_i,
  output dit_pkg::stat_t      stat_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output dit_pkg::out_t       out_data_o
);

  localparam int unsigned VW  = dit_pkg::VALUE_BITS;
  localparam int unsigned MAX = dit_pkg::MAX_INTERVALS;

  logic [VW-1:0]             starts_q [MAX];
  logic [VW-1:0]             ends_q   [MAX];
  logic [VW-1:0]             start_d  [MAX];
  logic [VW-1:0]             end_d    [MAX];
  logic [dit_pkg::CNT_W-1:0] count_q, count_d;
  logic [VW-1:0]             value_q;
  logic [dit_pkg::IDX_W-1:0] idx_q;

  // compare flags; below and le are masked with entry validity
  logic [MAX-1:0] below_q, below_d;  // end + 1 < value
  logic [MAX-1:0] le_q, le_d;        // start <= value + 1
  logic [MAX-1:0] slt_q, slt_d;      // value < start
  logic [MAX-1:0] egt_q, egt_d;      // value > end

  logic [MAX-1:0] at_vec, join_vec;
  logic           hit, join_add, full, insert;

  dit_pkg::out_t out_q, out_d;
  logic          out_valid_q;

  // Parallel compare of the incoming value against every entry.
  for (genvar i = 0; i < MAX; i++) begin : g_cmp
    logic          vld;
    logic [VW:0]   end_p1, val_p1, val_x, start_x;
    assign vld     = dit_pkg::CNT_W'(i) < count_q;
    assign end_p1  = {1'b0, ends_q[i]} + {{VW{1'b0}}, 1'b1};
    assign val_x   = {1'b0, in_data_i.value};
    assign val_p1  = val_x + {{VW{1'b0}}, 1'b1};
    assign start_x = {1'b0, starts_q[i]};
    assign below_d[i] = vld && (end_p1 < val_x);
    assign le_d[i]    = vld && (start_x <= val_p1);
    assign slt_d[i]   = in_data_i.value < starts_q[i];
    assign egt_d[i]   = in_data_i.value > ends_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      value_q <= in_data_i.value;
      below_q <= below_d;
      le_q    <= le_d;
      slt_q   <= slt_d;
      egt_q   <= egt_d;
    end
  end

  // Entries below the insert point stay; the first entry not below it is
  // the one the value touches or the slot for a new interval.
  for (genvar i = 0; i < MAX; i++) begin : g_ent
    logic          prev_below, nxt_le, ge, at;
    logic [VW-1:0] ps, pe, ns, ne;
    if (i == 0) begin : g_first
      assign prev_below = 1'b1;
      assign ps         = starts_q[i];
      assign pe         = ends_q[i];
    end else begin : g_mid
      assign prev_below = below_q[i-1];
      assign ps         = starts_q[i-1];
      assign pe         = ends_q[i-1];
    end
    if (i == MAX - 1) begin : g_top
      assign nxt_le = 1'b0;
      assign ns     = starts_q[i];
      assign ne     = ends_q[i];
    end else begin : g_low
      assign nxt_le = le_q[i+1];
      assign ns     = starts_q[i+1];
      assign ne     = ends_q[i+1];
    end
    assign ge          = !below_q[i];
    assign at          = ge && prev_below;
    assign at_vec[i]   = at;
    assign join_vec[i] = at && nxt_le;

    always_comb begin
      start_d[i] = starts_q[i];
      end_d[i]   = ends_q[i];
      if (hit) begin
        if (at) begin
          start_d[i] = slt_q[i] ? value_q : starts_q[i];
          if (join_add) begin
            end_d[i] = ne;
          end else begin
            end_d[i] = egt_q[i] ? value_q : ends_q[i];
          end
        end else if (ge && join_add) begin
          start_d[i] = ns;
          end_d[i]   = ne;
        end
      end else if (insert) begin
        if (at) begin
          start_d[i] = value_q;
          end_d[i]   = value_q;
        end else if (ge) begin
          start_d[i] = ps;
          end_d[i]   = pe;
        end
      end
    end
  end

  assign hit      = |(at_vec & le_q);
  assign join_add = hit && (|join_vec);
  assign full     = !hit && (count_q == dit_pkg::CNT_W'(MAX));
  assign insert   = !hit && !full;

  always_comb begin
    count_d = count_q;
    if (join_add) begin
      count_d = count_q - dit_pkg::CNT_W'(1);
    end else if (insert) begin
      count_d = count_q + dit_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      for (int k = 0; k < MAX; k++) begin
        starts_q[k] <= start_d[k];
        ends_q[k]   <= end_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.upd) begin
      count_q <= count_d;
    end
  end

  // Dump walks the table one entry per result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.take) begin
      idx_q <= '0;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + dit_pkg::IDX_W'(1);
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.dump_last = (count_q == '0) ||
                            (dit_pkg::CNT_W'(idx_q) + dit_pkg::CNT_W'(1) == count_q);

  always_comb begin
    out_d = '0;
    if (cmd_i.upd) begin
      out_d.result_kind    = dit_pkg::KIND_ACK;
      out_d.is_last        = 1'b1;
      out_d.status         = full ? dit_pkg::STATUS_DROPPED : dit_pkg::STATUS_OK;
      out_d.interval_count = count_d;
    end else begin
      out_d.result_kind    = dit_pkg::KIND_DUMP;
      out_d.is_last        = stat_o.dump_last;
      out_d.status         = dit_pkg::STATUS_OK;
      out_d.interval_count = count_q;
      if (count_q == '0) begin
        out_d.is_empty = 1'b1;
      end else begin
        out_d.range_start = starts_q[idx_q];
        out_d.range_end   = ends_q[idx_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd || cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.upd || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : dit_datapath
`default_nettype wire

[rtl/core/disjoint_interval_tracker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// disjoint_interval_tracker
// Sorted table of disjoint, non-adjacent intervals with add and dump.
// ---------------------------------------------------------------------------
// An add runs through the input transfer, which compares the value against
// every stored interval in parallel and registers the flags, and the update
// state, which shifts or merges the table and loads the acknowledgement;
// the next input is taken after the update. A dump reads the stored
// intervals from the table one per result, or a single empty result for
// an empty table. Results leave through one output register, so the block
// takes a new input while a result waits; a stall on the output side holds
// the update or the dump walk until the output register frees up. The table
// holds up to dit_pkg::MAX_INTERVALS intervals and starts empty after reset;
// a value that touches no interval while the table is full is dropped and
// its acknowledgement carries the dropped status.
// ---------------------------------------------------------------------------
module disjoint_interval_tracker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dit_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output dit_pkg::out_t      out_data_o
);

  dit_pkg::cmd_t  cmd;
  dit_pkg::stat_t stat;

  // Sequence transfers, updates and dump steps.
  dit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the table, compare, merge and drive results.
  dit_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule : disjoint_interval_tracker
`default_nettype wire

[rtl/core/dit_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dit_checker
// Port-level checks of the disjoint interval tracker.
// ---------------------------------------------------------------------------
module dit_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire dit_pkg::out_t out_data_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_ack_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == dit_pkg::KIND_ACK |->
      out_data_o.range_start == '0 && out_data_o.range_end == '0 &&
      out_data_o.is_last && !out_data_o.is_empty)
    else $error("malformed acknowledgement");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.interval_count <= dit_pkg::CNT_W'(dit_pkg::MAX_INTERVALS))
    else $error("interval count out of range");

  a_empty_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |->
      out_data_o.result_kind == dit_pkg::KIND_DUMP && out_data_o.is_last &&
      out_data_o.interval_count == '0 &&
      out_data_o.status == dit_pkg::STATUS_OK)
    else $error("malformed empty dump");

  a_interval_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == dit_pkg::KIND_DUMP &&
      !out_data_o.is_empty |->
      out_data_o.range_start <= out_data_o.range_end)
    else $error("reported interval is reversed");

endmodule : dit_checker

bind disjoint_interval_tracker dit_checker u_dit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
